// File: rtl/tqsi_pkg.sv
package tqsi_pkg;

  // Field widths of the transactions and registers.
  localparam int unsigned ID_W       = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

  // Enqueue modes; the unused fourth code behaves as sorted mode.
  localparam logic [MODE_W-1:0] MODE_REGULAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE_REAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SORTED    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENQUEUE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_IDLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK_ID = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [ID_W-1:0]  task_id;
    logic [CNT_W-1:0] sort_key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_task_id;
    logic [CNT_W-1:0]    out_block_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
  } cmd_t;

endpackage

// File: rtl/tqsi_ctrl.sv
module tqsi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output tqsi_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   take_in;
  logic   out_free;

  // A new transaction is taken only in idle; the result register frees when drained.
  assign take_in  = (state_r == ST_IDLE) && in_valid && !in_stall_r;
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.load  = take_in;
  assign cmd.eval  = (state_r == ST_EVAL);
  assign cmd.apply = (state_r == ST_APPLY) && out_free;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register fills on apply and empties when the receiver takes it.
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (take_in) begin
            state_r    <= ST_EVAL;
            in_stall_r <= 1'b1;
          end
        end
        ST_EVAL: begin
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (out_free) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/tqsi_dp.sv
module tqsi_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tqsi_pkg::cmd_t                      cmd,
  input  tqsi_pkg::in_item_t                  in_payload,
  output tqsi_pkg::out_item_t                 out_payload,
  input  logic                                cfg_we,
  input  logic [tqsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tqsi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  // Configuration registers.
  logic [tqsi_pkg::MODE_W-1:0] mode_r;
  logic                        guard_r;
  logic [tqsi_pkg::ID_W-1:0]   idle_id_r;

  // Queue cells, position 0 is the head.
  logic [tqsi_pkg::ID_W-1:0]  ids_r [DEPTH];
  logic [tqsi_pkg::CNT_W-1:0] cnt_r [DEPTH];
  logic [tqsi_pkg::ID_W-1:0]  id_nxt [DEPTH];
  logic [tqsi_pkg::CNT_W-1:0] cnt_nxt [DEPTH];
  logic [OCC_W-1:0]           occ_r;
  logic [OCC_W-1:0]           occ_nxt;

  tqsi_pkg::in_item_t  item_r;
  tqsi_pkg::out_item_t out_r;
  tqsi_pkg::out_item_t out_nxt;

  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] match_r;
  logic [DEPTH-1:0] shift_up;

  logic head_idle;
  logic is_enq;
  logic enq_ok;
  logic deq_ok;

  assign head_idle = (ids_r[0] == idle_id_r);
  assign is_enq    = (item_r.operation == tqsi_pkg::OP_ENQUEUE);
  assign enq_ok    = is_enq && (occ_r != OCC_FULL);
  assign deq_ok    = !is_enq && (occ_r != '0) && !(guard_r && head_idle);

  // Per-cell compare and move selection. The first flagged cell is the insert
  // point; the cell one past the tail is always flagged so an append falls out.
  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    logic                       valid;
    logic                       cmp;
    logic [tqsi_pkg::ID_W-1:0]  up_id;
    logic [tqsi_pkg::CNT_W-1:0] up_cnt;
    logic [tqsi_pkg::ID_W-1:0]  dn_id;
    logic [tqsi_pkg::CNT_W-1:0] dn_cnt;

    assign valid = (OCC_W'(g) < occ_r);

    if (g == 0) begin : g_head
      assign cmp         = (cnt_r[g] > item_r.sort_key);
      assign shift_up[g] = 1'b0;
      assign up_id       = ids_r[g];
      assign up_cnt      = cnt_r[g];
    end else begin : g_body
      assign cmp         = (cnt_r[g] >= item_r.sort_key);
      assign shift_up[g] = |match_r[g-1:0];
      assign up_id       = ids_r[g-1];
      assign up_cnt      = cnt_r[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign dn_id  = ids_r[g];
      assign dn_cnt = cnt_r[g];
    end else begin : g_inner
      assign dn_id  = ids_r[g+1];
      assign dn_cnt = cnt_r[g+1];
    end

    always_comb begin
      case (mode_r)
        tqsi_pkg::MODE_REGULAR:   hit[g] = 1'b0;
        tqsi_pkg::MODE_IDLE_REAR: hit[g] = valid && (ids_r[g] == idle_id_r);
        default:                  hit[g] = valid && cmp;
      endcase
      if (OCC_W'(g) == occ_r) begin
        hit[g] = 1'b1;
      end
    end

    always_comb begin
      id_nxt[g]  = ids_r[g];
      cnt_nxt[g] = cnt_r[g];
      if (enq_ok) begin
        if (shift_up[g]) begin
          id_nxt[g]  = up_id;
          cnt_nxt[g] = up_cnt;
        end else if (match_r[g]) begin
          id_nxt[g]  = item_r.task_id;
          cnt_nxt[g] = item_r.sort_key;
        end
      end else if (deq_ok) begin
        id_nxt[g]  = dn_id;
        cnt_nxt[g] = dn_cnt;
      end
    end
  end

  // Result and occupancy for the current transaction.
  always_comb begin
    out_nxt = '0;
    occ_nxt = occ_r;
    if (is_enq) begin
      if (enq_ok) begin
        occ_nxt = occ_r + 1'b1;
      end else begin
        out_nxt.status = tqsi_pkg::STAT_FULL;
      end
    end else if (occ_r == '0) begin
      out_nxt.status = tqsi_pkg::STAT_EMPTY;
    end else if (guard_r && head_idle) begin
      out_nxt.status = tqsi_pkg::STAT_REFUSED;
    end else begin
      out_nxt.out_task_id     = ids_r[0];
      out_nxt.out_block_count = cnt_r[0];
      occ_nxt                 = occ_r - 1'b1;
    end
  end

  // Control state: occupancy and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      mode_r    <= tqsi_pkg::MODE_REGULAR;
      guard_r   <= 1'b0;
      idle_id_r <= '0;
    end else begin
      if (cmd.apply) begin
        occ_r <= occ_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          tqsi_pkg::CFG_ENQUEUE_MODE: mode_r    <= cfg_wdata[tqsi_pkg::MODE_W-1:0];
          tqsi_pkg::CFG_GUARD_IDLE:   guard_r   <= cfg_wdata[0];
          tqsi_pkg::CFG_IDLE_TASK_ID: idle_id_r <= cfg_wdata[tqsi_pkg::ID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: input latch, match flags, queue cells and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_payload;
    end
    if (cmd.eval) begin
      match_r <= hit;
    end
    if (cmd.apply) begin
      out_r <= out_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        ids_r[i] <= id_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign out_payload = out_r;

endmodule

// File: rtl/task_queue_sorted_insert.sv
// Each transaction is accepted in idle, evaluated (every queue cell compares its entry
// in parallel and the match flags are registered) and applied (the cells shift and the
// result is registered); a new transaction is taken only after the last one is applied.
// The next transaction may enter while a result waits; its shift waits for the drain.
// Reset (rst_n low at a clock edge) empties the queue and clears all config registers.
module task_queue_sorted_insert #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tqsi_pkg::in_item_t              in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tqsi_pkg::out_item_t             out_payload,
  input  logic                            cfg_we,
  input  logic [tqsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tqsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tqsi_pkg::cmd_t cmd;

  // Sequencer for the handshakes.
  tqsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Queue cells, compare logic and result register.
  tqsi_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_payload  (in_payload),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

endmodule
